@@ design/tps_pkg.sv @@
package tps_pkg;

  localparam int ADDR_W = 64;
  localparam int SIZE_W = 32;
  localparam int LEN_W = 13;
  localparam int LIMIT_W = 4;
  localparam int STATUS_W = 3;
  localparam int KIND_W = 2;
  localparam int STICKY_W = 2;
  localparam int INFLIGHT_W = 16;

  // The page below the window base is one 32-bit word.
  localparam int SMALL_BITS = 2;
  localparam logic [SMALL_BITS:0] SMALL_PAGE = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_COMPL = 1'b1;

  localparam logic [KIND_W-1:0] KIND_REQ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TXN = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FAULT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ADDR = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SIZE = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd6;

  localparam logic [STICKY_W-1:0] STICKY_OK = 2'd0;
  localparam logic [STICKY_W-1:0] STICKY_TXN = 2'd1;
  localparam logic [STICKY_W-1:0] STICKY_FAULT = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd1;

  localparam logic [1:0] CMD_REJECT = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_COMPL = 2'd2;

  typedef struct packed {
    logic action;
    logic [ADDR_W-1:0] start_addr;
    logic [SIZE_W-1:0] total_size;
    logic completion_ok;
    logic [LIMIT_W-1:0] accept_limit;
    logic issue_fault;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] req_addr;
    logic [LEN_W-1:0] req_len;
    logic [STATUS_W-1:0] result_status;
    logic last;
  } result_t;

  typedef struct packed {
    logic [1:0] op;
    logic [STATUS_W-1:0] code;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic ok;
    logic [LIMIT_W-1:0] limit;
    logic fault;
  } cmd_t;

endpackage

@@ design/transfer_page_splitter.sv @@
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_ready      item (item_t)
// result    out        result_valid / result_ready  result (result_t)
// cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// An item is registered in the front stage and then waits in a four-entry queue.
// The back sets up a start or completion in its idle and page states, issues
// requests one by one and closes in its final state; a rejection is sent from
// idle. Reset is synchronous; it clears the window base and size, the valid
// flags, queue pointers, state, in-flight count and sticky status. Either side
// may stall on its own: the queue fills while the result register waits to be taken.
module transfer_page_splitter import tps_pkg::*; #(
  parameter int PAGE_BITS = 12,
  parameter int MAX_REQ = 1024,
  parameter int ALIGN_MASK = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  logic [ADDR_W-1:0] window_base;
  logic              fr_valid;
  logic              fr_ready;
  cmd_t              fr_cmd;
  logic              bk_valid;
  logic              bk_ready;
  cmd_t              bk_cmd;

  tps_front #(
    .ALIGN_MASK(ALIGN_MASK)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .window_base(window_base),
    .cmd_valid  (fr_valid),
    .cmd_ready  (fr_ready),
    .cmd        (fr_cmd)
  );

  tps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fr_valid),
    .push_ready(fr_ready),
    .push_cmd  (fr_cmd),
    .pop_valid (bk_valid),
    .pop_ready (bk_ready),
    .pop_cmd   (bk_cmd)
  );

  tps_back #(
    .PAGE_BITS(PAGE_BITS),
    .MAX_REQ  (MAX_REQ)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .window_base (window_base),
    .cmd_valid   (bk_valid),
    .cmd_ready   (bk_ready),
    .cmd         (bk_cmd),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  // Requests are never empty and never exceed the request limit.
  a_req_len: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.kind == KIND_REQ)) |->
      ((result.req_len != '0) && (32'(result.req_len) <= 32'(MAX_REQ))))
    else $error("request length out of range");

  // Finished and rejected results always close their item.
  a_close_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.kind != KIND_REQ)) |-> result.last)
    else $error("closing result without last");

  // A rejection never comes from a start that passed its checks.
  a_reject_code: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.kind == KIND_REJECT)) |->
      ((result.result_status == ST_RANGE) || (result.result_status == ST_ADDR) ||
       (result.result_status == ST_SIZE) || (result.result_status == ST_EMPTY)))
    else $error("rejection with a non-rejection status");

endmodule

@@ design/tps_front.sv @@
module tps_front import tps_pkg::*; #(
  parameter int ALIGN_MASK = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  output logic [ADDR_W-1:0]    window_base,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd
);

  logic [SIZE_W-1:0] window_size;
  logic [ADDR_W:0]   window_end;
  logic              stage_valid;
  item_t             stage;
  logic [ADDR_W:0]   stage_end;
  logic [STATUS_W-1:0] code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= '0;
      window_size <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WINDOW_BASE) begin
        window_base <= cfg_data;
      end else if (cfg_index == REG_WINDOW_SIZE) begin
        window_size <= cfg_data[SIZE_W-1:0];
      end
    end
  end

  // The window end is a register on the base and size; the user is to change
  // configuration only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    window_end <= {1'b0, window_base} + {{(ADDR_W - SIZE_W + 1){1'b0}}, window_size};
  end

  assign item_ready = !stage_valid || cmd_ready;
  assign cmd_valid  = stage_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage     <= item;
      stage_end <= {1'b0, item.start_addr} +
                   {{(ADDR_W - SIZE_W + 1){1'b0}}, item.total_size};
    end
  end

  always_comb begin
    if (stage_end > window_end) begin
      code = ST_RANGE;
    end else if ((stage.start_addr & ADDR_W'(ALIGN_MASK)) != '0) begin
      code = ST_ADDR;
    end else if ((stage.total_size & SIZE_W'(ALIGN_MASK)) != '0) begin
      code = ST_SIZE;
    end else if (stage.total_size == '0) begin
      code = ST_EMPTY;
    end else begin
      code = ST_OK;
    end
  end

  always_comb begin
    cmd.code  = code;
    cmd.addr  = stage.start_addr;
    cmd.size  = stage.total_size;
    cmd.ok    = stage.completion_ok;
    cmd.limit = stage.accept_limit;
    cmd.fault = stage.issue_fault;
    if (stage.action == ACT_COMPL) begin
      cmd.op = CMD_COMPL;
    end else if (code != ST_OK) begin
      cmd.op = CMD_REJECT;
    end else begin
      cmd.op = CMD_START;
    end
  end

endmodule

@@ design/tps_queue.sv @@
module tps_queue import tps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ design/tps_back.sv @@
module tps_back import tps_pkg::*; #(
  parameter int PAGE_BITS = 12,
  parameter int MAX_REQ = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] window_base,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result
);

  localparam int REM_W = PAGE_BITS + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PAGE  = 2'd1;
  localparam logic [1:0] S_ISSUE = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  logic [1:0]            state;
  logic [ADDR_W-1:0]     here;
  logic [SIZE_W-1:0]     left;
  logic [INFLIGHT_W-1:0] inflight;
  logic [STICKY_W-1:0]   sticky;
  logic [LIMIT_W-1:0]    taken;
  logic [LIMIT_W-1:0]    limit;
  logic                  fault;
  logic                  mode_start;
  logic                  small_page;

  logic                  out_free;
  logic [REM_W-1:0]      rem_big;
  logic [SMALL_BITS:0]   rem_small;
  logic [SIZE_W-1:0]     rem;
  logic [SIZE_W-1:0]     cap;
  logic [SIZE_W-1:0]     cur;
  logic                  req_last;
  logic                  need_finish;
  logic                  emit;

  assign out_free = !result_valid || result_ready;

  // Bytes left in the current page, then capped by the request limit and
  // by what remains of the transfer.
  assign rem_big   = (REM_W'(1) << PAGE_BITS) - {1'b0, here[PAGE_BITS-1:0]};
  assign rem_small = SMALL_PAGE - {1'b0, here[SMALL_BITS-1:0]};
  assign rem       = small_page ? SIZE_W'(rem_small) : SIZE_W'(rem_big);
  assign cap       = (rem > SIZE_W'(MAX_REQ)) ? SIZE_W'(MAX_REQ) : rem;
  assign cur       = (cap > left) ? left : cap;

  // A request is the final result of its item when the batch stops right
  // after it, unless a completion's in-flight count wraps round to zero.
  assign req_last = ((left == cur) ||
                     (({1'b0, taken} + 5'd1) >= {1'b0, limit})) &&
                    (mode_start || ((inflight + 1'b1) != '0));

  assign need_finish = mode_start ? ((sticky != STICKY_OK) && (taken == '0))
                                  : (inflight == '0);

  assign cmd_ready = (state == S_IDLE) && ((cmd.op != CMD_REJECT) || out_free);

  // A new result is loaded into the output register in this cycle.
  always_comb begin
    case (state)
      S_IDLE: begin
        emit = cmd_valid && (cmd.op == CMD_REJECT) && out_free;
      end
      S_ISSUE: begin
        emit = (sticky == STICKY_OK) && (left != '0) && (taken < limit) && out_free;
      end
      S_FINAL: begin
        emit = need_finish && out_free;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      inflight     <= '0;
      sticky       <= STICKY_OK;
    end else begin
      result_valid <= emit || (result_valid && !result_ready);
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              CMD_REJECT: begin
                if (out_free) begin
                  result <= '{kind: KIND_REJECT, req_addr: '0, req_len: '0,
                              result_status: cmd.code, last: 1'b1};
                end
              end
              CMD_START: begin
                here       <= cmd.addr;
                left       <= cmd.size;
                inflight   <= '0;
                sticky     <= STICKY_OK;
                taken      <= '0;
                limit      <= cmd.limit;
                fault      <= cmd.fault;
                mode_start <= 1'b1;
                state      <= S_PAGE;
              end
              CMD_COMPL: begin
                // A completion with nothing in flight is dropped.
                if (inflight != '0) begin
                  inflight <= inflight - 1'b1;
                  if (!cmd.ok && (sticky == STICKY_OK)) begin
                    sticky <= STICKY_TXN;
                  end
                  taken      <= '0;
                  limit      <= cmd.limit;
                  fault      <= cmd.fault;
                  mode_start <= 1'b0;
                  state      <= S_PAGE;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_PAGE: begin
          small_page <= (here < window_base);
          state      <= S_ISSUE;
        end
        S_ISSUE: begin
          if ((sticky != STICKY_OK) || (left == '0)) begin
            state <= S_FINAL;
          end else if (taken >= limit) begin
            if (fault) begin
              sticky <= STICKY_FAULT;
            end
            state <= S_FINAL;
          end else if (out_free) begin
            result <= '{kind: KIND_REQ, req_addr: here, req_len: cur[LEN_W-1:0],
                        result_status: ST_OK, last: req_last};
            taken    <= taken + 1'b1;
            inflight <= inflight + 1'b1;
            here     <= here + ADDR_W'(cur);
            left     <= left - cur;
          end
        end
        S_FINAL: begin
          if (!need_finish) begin
            state <= S_IDLE;
          end else if (out_free) begin
            result <= '{kind: KIND_DONE, req_addr: '0, req_len: '0,
                        result_status: STATUS_W'(sticky), last: 1'b1};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import tps_pkg::*;

  localparam int PAGE_BITS = 12;
  localparam int MAX_REQ = 1024;
  localparam int ALIGN_MASK = 3;

  localparam int MAX_GAP = 11;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 380;
  localparam int MAX_REPORTS = 200;

  localparam logic [ADDR_W-1:0] DIR_BASE = 64'h0000_0040_0000_0000;
  localparam logic [SIZE_W-1:0] DIR_SIZE = 32'h0010_0000;

  class split_scoreboard;
    logic [ADDR_W-1:0] win_base;
    logic [SIZE_W-1:0] win_size;
    logic [ADDR_W-1:0] xfer_base;
    logic [SIZE_W-1:0] xfer_len;
    logic [SIZE_W-1:0] position;
    logic [INFLIGHT_W-1:0] inflight;
    logic [31:0] started;
    logic [STICKY_W-1:0] sticky;
    result_t expected_results[$];
    int unsigned checked;
    int unsigned errors;

    function new();
      win_base = '0;
      win_size = '0;
      xfer_base = '0;
      xfer_len = '0;
      position = '0;
      inflight = '0;
      started = '0;
      sticky = STICKY_OK;
      checked = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [ADDR_W-1:0] data);
      if (index == REG_WINDOW_BASE) win_base = data;
      else if (index == REG_WINDOW_SIZE) win_size = data[SIZE_W-1:0];
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void push(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                       logic [LEN_W-1:0] len, logic [STATUS_W-1:0] status);
      result_t r;
      r.kind = kind;
      r.req_addr = addr;
      r.req_len = len;
      r.result_status = status;
      r.last = 1'b0;
      expected_results.push_back(r);
    endfunction

    // Issues requests until the transfer is done, an error is latched or the
    // downstream refuses. Returns 1 when it stopped on an error.
    function bit issue_requests(logic [LIMIT_W-1:0] limit, logic fault);
      logic [ADDR_W-1:0] here;
      logic [ADDR_W-1:0] page;
      logic [ADDR_W-1:0] cur;
      logic [SIZE_W-1:0] left;
      int unsigned taken;
      here = xfer_base + {32'd0, position};
      // The page size holds for the whole step, even if the step crosses the base.
      page = (here < win_base) ? {{(ADDR_W-SMALL_BITS-1){1'b0}}, SMALL_PAGE}
                               : (64'd1 << PAGE_BITS);
      taken = 0;
      while (1) begin
        if (sticky != STICKY_OK) return 1'b1;
        left = xfer_len - position;
        if (left == 0) return 1'b0;
        here = xfer_base + {32'd0, position};
        cur = page - (here & (page - 64'd1));
        if (cur > 64'(MAX_REQ)) cur = 64'(MAX_REQ);
        if (cur > {32'd0, left}) cur = {32'd0, left};
        if (taken >= limit) begin
          if (fault) begin
            sticky = STICKY_FAULT;
            return 1'b1;
          end
          return 1'b0;
        end
        push(KIND_REQ, here, cur[LEN_W-1:0], ST_OK);
        taken++;
        started++;
        inflight++;
        position += cur[SIZE_W-1:0];
      end
    endfunction

    function void note_item(item_t it);
      int unsigned first;
      logic [ADDR_W:0] end_addr;
      logic [ADDR_W:0] win_end;
      logic [STATUS_W-1:0] code;
      result_t r;
      first = expected_results.size();
      if (it.action == ACT_START) begin
        end_addr = {1'b0, it.start_addr} + {33'd0, it.total_size};
        win_end = {1'b0, win_base} + {33'd0, win_size};
        code = ST_OK;
        if (end_addr > win_end) code = ST_RANGE;
        else if ((it.start_addr & ALIGN_MASK) != 0) code = ST_ADDR;
        else if ((it.total_size & ALIGN_MASK) != 0) code = ST_SIZE;
        else if (it.total_size == 0) code = ST_EMPTY;
        if (code != ST_OK) begin
          push(KIND_REJECT, '0, '0, code);
        end else begin
          xfer_base = it.start_addr;
          xfer_len = it.total_size;
          position = '0;
          inflight = '0;
          started = '0;
          sticky = STICKY_OK;
          if (issue_requests(it.accept_limit, it.issue_fault) && started == 0)
            push(KIND_DONE, '0, '0, {1'b0, sticky});
        end
      end else if (inflight != 0) begin
        if (!it.completion_ok && sticky == STICKY_OK) sticky = STICKY_TXN;
        void'(issue_requests(it.accept_limit, it.issue_fault));
        inflight--;
        if (inflight == 0) push(KIND_DONE, '0, '0, {1'b0, sticky});
      end
      if (expected_results.size() > first) begin
        r = expected_results.pop_back();
        r.last = 1'b1;
        expected_results.push_back(r);
      end
    endfunction

    task report(string msg);
      errors++;
      // Only the first mismatches are printed; the count goes on.
      if (errors <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_result(result_t got);
      result_t want;
      checked++;
      if (expected_results.size() == 0) begin
        report($sformatf("result %0d unexpected: kind %0d addr %h len %0d status %0d",
                         checked, got.kind, got.req_addr, got.req_len, got.result_status));
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("result %0d kind %0d, expected %0d", checked, got.kind, want.kind));
      if (got.req_addr !== want.req_addr)
        report($sformatf("result %0d addr %h, expected %h", checked, got.req_addr,
                         want.req_addr));
      if (got.req_len !== want.req_len)
        report($sformatf("result %0d len %0d, expected %0d", checked, got.req_len,
                         want.req_len));
      if (got.result_status !== want.result_status)
        report($sformatf("result %0d status %0d, expected %0d", checked,
                         got.result_status, want.result_status));
      if (got.last !== want.last)
        report($sformatf("result %0d last %0d, expected %0d", checked, got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  item_t item;
  logic result_valid;
  logic result_ready;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0] cfg_data;

  split_scoreboard sb;
  bit tx_burst;
  int unsigned items_counted;
  int unsigned hold_requests;

  transfer_page_splitter #(
    .PAGE_BITS(PAGE_BITS),
    .MAX_REQ(MAX_REQ),
    .ALIGN_MASK(ALIGN_MASK)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic item_t make_start(logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] size,
                                       logic [LIMIT_W-1:0] limit, logic fault);
    item_t it;
    it.action = ACT_START;
    it.start_addr = addr;
    it.total_size = size;
    it.completion_ok = 1'($urandom_range(0, 1));
    it.accept_limit = limit;
    it.issue_fault = fault;
    return it;
  endfunction

  function automatic item_t make_compl(logic ok, logic [LIMIT_W-1:0] limit, logic fault);
    item_t it;
    it.action = ACT_COMPL;
    it.start_addr = {$urandom, $urandom};
    it.total_size = $urandom;
    it.completion_ok = ok;
    it.accept_limit = limit;
    it.issue_fault = fault;
    return it;
  endfunction

  // A start that passes every check, mostly inside the window and sometimes
  // just below its base, where the pages are one word long.
  function automatic item_t good_start();
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    if (sb.win_base >= 64'd256 && $urandom_range(0, 4) == 0) begin
      addr = sb.win_base - (64'($urandom_range(1, 48)) << 2);
      size = $urandom_range(1, 24) << 2;
    end else begin
      if ($urandom_range(0, 9) == 0) size = $urandom_range(1, 16384) << 2;
      else size = $urandom_range(1, 2048) << 2;
      addr = sb.win_base + (64'($urandom_range(0, 32767)) << 2);
    end
    return make_start(addr, size, LIMIT_W'($urandom_range(0, 15)),
                      $urandom_range(0, 3) == 0);
  endfunction

  function automatic item_t broken_start();
    item_t it;
    it = good_start();
    case ($urandom_range(0, 3))
      0: it.start_addr[1:0] = 2'($urandom_range(1, 3));
      1: it.total_size[1:0] = 2'($urandom_range(1, 3));
      2: it.total_size = '0;
      default: begin
        it.start_addr = sb.win_base + {32'd0, sb.win_size} - (64'($urandom_range(0, 64)) << 2);
        it.total_size = $urandom_range(65, 512) << 2;
      end
    endcase
    return it;
  endfunction

  // Valid stays high between back-to-back transfers, so it is only lowered
  // when a gap is drawn.
  task automatic send_item(item_t it);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    if (!(it.action == ACT_COMPL && sb.inflight == 0)) items_counted++;
    sb.note_item(it);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Ignored completions may still sit in the queue.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] size);
    logic [ADDR_W-1:0] size_word;
    size_word = {$urandom, size};
    cfg_valid <= 1'b1;
    cfg_index <= REG_WINDOW_BASE;
    cfg_data <= base;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_WINDOW_BASE, base);
    cfg_index <= REG_WINDOW_SIZE;
    cfg_data <= size_word;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_WINDOW_SIZE, size_word);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_transfer(bit may_abandon);
    while (sb.inflight != 0) begin
      // An abandoned transfer is overtaken by the next start.
      if (may_abandon && $urandom_range(0, 29) == 0) break;
      send_item(make_compl($urandom_range(0, 19) != 0, LIMIT_W'($urandom_range(0, 15)),
                           $urandom_range(0, 7) == 0));
    end
  endtask

  task automatic run_sequence();
    tx_burst = ($urandom_range(0, 3) == 0);
    send_item(good_start());
    drain_transfer(1'b1);
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned target;
    int unsigned pick;
    target = items_counted + count;
    while (items_counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        run_sequence();
      end else if (pick < 80) begin
        send_item(make_start({$urandom, $urandom}, $urandom,
                             LIMIT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end else if (pick < 92) begin
        send_item(broken_start());
      end else begin
        send_item(make_compl(1'($urandom_range(0, 1)), LIMIT_W'($urandom_range(0, 15)),
                             1'($urandom_range(0, 1))));
      end
    end
  endtask

  initial begin
    int unsigned rx_gap;
    int unsigned holds_served;
    bit rx_burst;
    result_ready <= 1'b0;
    rx_gap = 0;
    holds_served = 0;
    rx_burst = 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) begin
        sb.check_result(result);
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        rx_gap = LONG_HOLD;
      end
      if (rx_gap != 0) begin
        result_ready <= 1'b0;
        rx_gap--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    sb = new();
    tx_burst = 1'b0;
    items_counted = 0;
    hold_requests = 0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_WINDOW_BASE;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_window(DIR_BASE, DIR_SIZE);
    send_item(make_compl(1'b1, 4'd15, 1'b0));
    send_item(make_start(DIR_BASE + DIR_SIZE, 32'd4, 4'd15, 1'b0));
    send_item(make_start(DIR_BASE + DIR_SIZE - 16, 32'd20, 4'd15, 1'b0));
    send_item(make_start(DIR_BASE + 2, 32'd8, 4'd15, 1'b0));
    send_item(make_start(DIR_BASE, 32'd6, 4'd15, 1'b0));
    send_item(make_start(DIR_BASE, 32'd0, 4'd15, 1'b0));
    // Refused at once: a fault finishes the transfer, a busy refusal leaves it waiting.
    send_item(make_start(DIR_BASE, 32'd64, 4'd0, 1'b1));
    send_item(make_start(DIR_BASE, 32'd64, 4'd0, 1'b0));
    send_item(make_compl(1'b1, 4'd15, 1'b0));
    send_item(make_start(DIR_BASE + DIR_SIZE - 16, 32'd16, 4'd15, 1'b0));
    send_item(make_compl(1'b1, 4'd15, 1'b0));
    send_item(make_start(DIR_BASE + 32'hF00, 32'h1800, 4'd15, 1'b0));
    send_item(make_compl(1'b0, 4'd15, 1'b0));
    drain_transfer(1'b0);
    send_item(make_start(DIR_BASE, 32'h4000, 4'd2, 1'b1));
    drain_transfer(1'b0);
    send_item(make_start(DIR_BASE, 32'h3C00, 4'd15, 1'b0));
    send_item(make_start(DIR_BASE + 32'h10000, 32'd8, 4'd1, 1'b0));
    drain_transfer(1'b0);
    // The last request completes with bytes still unissued.
    send_item(make_start(DIR_BASE, 32'h1000, 4'd1, 1'b0));
    send_item(make_compl(1'b1, 4'd0, 1'b0));
    send_item(make_start(DIR_BASE - 8, 32'd16, 4'd3, 1'b0));
    drain_transfer(1'b0);
    wait_idle();

    write_window(64'h0000_0000_8000_0000, 32'h0010_0000);
    // The receiver holds off while the sender keeps the queue full.
    hold_requests++;
    tx_burst = 1'b1;
    send_item(make_start(64'h0000_0000_8000_0000, 32'h8000, 4'd15, 1'b0));
    while (sb.inflight != 0) send_item(make_compl(1'b1, 4'd15, 1'b0));
    random_phase(70);
    wait_idle();

    write_window(64'hFFFF_FFFF_FFFF_0000, 32'hFFFF_FFFF);
    random_phase(60);
    wait_idle();

    write_window(64'd0, 32'd0);
    send_item(make_start(64'd0, 32'd0, 4'd15, 1'b0));
    random_phase(15);
    wait_idle();

    write_window({$urandom, $urandom}, $urandom_range(32'h0010_0000, 32'hFFFF_FFFF));
    random_phase(60);
    wait_idle();

    write_window(64'd0, 32'hFFFF_FFFF);
    random_phase(40);
    wait_idle();

    // The last phase tops the run up to the intended number of items.
    write_window(64'h0000_0000_0000_1000, 32'h0008_0000);
    if (items_counted < RANDOM_ITEMS) random_phase(RANDOM_ITEMS - items_counted);
    wait_idle();

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
